// File: design/bss_pkg.sv
// Package for the bounded substring search block.
// Holds transaction types, register indexes, field widths and the case-fold helper.
// Depends on nothing.
package bss_pkg;

    // Field widths fixed by the interface
    localparam int ByteW      = 8;
    localparam int LenW       = 4;
    localparam int PosW       = 16;
    localparam int PatW       = 64;
    localparam int PatSlots   = PatW / ByteW;
    localparam int CfgIndexW  = 2;

    // Defaults for the top-level parameters
    localparam int DefMaxPattern = 8;
    localparam int DefMaxBuffer  = 65535;

    // Configuration register indexes
    localparam logic [CfgIndexW-1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [CfgIndexW-1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [CfgIndexW-1:0] REG_IGNORE_CASE    = 2'd2;

    // ASCII letter bounds and fold offset
    localparam logic [ByteW-1:0] CharUpperA = 8'h41;
    localparam logic [ByteW-1:0] CharUpperZ = 8'h5A;
    localparam logic [ByteW-1:0] CaseOffset = 8'h20;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             last_byte;
    } item_t;

    typedef struct packed {
        logic            found;
        logic [PosW-1:0] match_position;
    } result_t;

    // Control handed to every cell of the window
    typedef struct packed {
        logic shift;
        logic clear;
        logic ignore_case;
    } cell_ctrl_t;

    // Fold ASCII upper case to lower when enabled
    function automatic logic [ByteW-1:0] fold_case(input logic [ByteW-1:0] c,
                                                   input logic             enable);
        logic [ByteW-1:0] r;
        r = c;
        if (enable && (c >= CharUpperA) && (c <= CharUpperZ))
        begin
            r = c + CaseOffset;
        end
        return r;
    endfunction

endpackage

// File: design/bss_cell.sv
// One cell of the byte window for the bounded substring search.
// Holds one window byte, passes it on, and compares the incoming byte with its pattern byte.
// Depends on bss_pkg.
module bss_cell
    import bss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [ByteW-1:0] shift_in,
    input  logic [ByteW-1:0] target,
    input  logic             in_use,
    input  logic             hit_in,
    output logic [ByteW-1:0] byte_out,
    output logic             hit_out
);

    logic [ByteW-1:0] byte_reg;
    logic [ByteW-1:0] byte_next;

    // Shift in the neighbour's byte; end of buffer clears the window
    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = '0;
        end
        else if (ctrl.shift)
        begin
            byte_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // Compare the byte that lands here this cycle; unused cells pass the hit through
    assign hit_out  = hit_in &
                      (!in_use ||
                       (fold_case(shift_in, ctrl.ignore_case) ==
                        fold_case(target, ctrl.ignore_case)));
    assign byte_out = byte_reg;

endmodule

// File: design/bounded_substring_search.sv
// Top level of the bounded substring search block.
// Holds configuration, the per-buffer counters, the cell window and the result register.
// Depends on bss_pkg and bss_cell.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  item     | item_valid, item_stall, item (item_t)     | in
//  result   | result_valid, result_stall, result        | out
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One byte is taken every cycle while item_stall is low; the output register takes a
// result the cycle after the byte that decides it. The compare runs across the row of
// window cells. item_stall rises only while a result waits there under result_stall.
// Reset clears the configuration, the window, the byte count and the done flag.
// Configuration writes are always taken (cfg_ready is tied high).
module bounded_substring_search
    import bss_pkg::*;
#(
    parameter int MAX_PATTERN = DefMaxPattern,
    parameter int MAX_BUFFER  = DefMaxBuffer
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [PatW-1:0]      cfg_data
);

    // Configuration registers
    logic [PatW-1:0] pattern_bytes_reg;
    logic [LenW-1:0] pattern_length_reg;
    logic            ignore_case_reg;

    // Per-buffer state
    logic [PosW-1:0] byte_count_reg;
    logic [PosW-1:0] byte_count_next;
    logic            search_done_reg;
    logic            search_done_next;

    // Output register
    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;

    logic            accept;
    logic            over_limit;
    logic [LenW-1:0] eff_len;
    logic [LenW-1:0] len_limit;
    logic [PosW-1:0] count_plus1;
    logic            match;
    logic            emit;
    result_t         outcome;
    cell_ctrl_t      ctrl;

    logic [ByteW-1:0] window [MAX_PATTERN];
    logic [ByteW-1:0] targets [MAX_PATTERN];
    logic             hits [MAX_PATTERN+1];

    assign cfg_ready  = 1'b1;
    assign item_stall = result_valid_reg & result_stall;
    assign accept     = item_valid & ~item_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
            ignore_case_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_data;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LenW-1:0];
                REG_IGNORE_CASE:    ignore_case_reg    <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Effective pattern length: capped, and cut at the first zero byte
    always_comb
    begin
        logic stop;
        stop      = 1'b0;
        eff_len   = '0;
        len_limit = (pattern_length_reg > LenW'(MAX_PATTERN)) ? LenW'(MAX_PATTERN)
                                                              : pattern_length_reg;
        for (int i = 0; i < PatSlots; i++)
        begin
            if (!stop && (LenW'(i) < len_limit) &&
                (pattern_bytes_reg[i*ByteW +: ByteW] != '0))
            begin
                eff_len = LenW'(i + 1);
            end
            else
            begin
                stop = 1'b1;
            end
        end
    end

    assign over_limit = (byte_count_reg >= PosW'(MAX_BUFFER));

    assign ctrl.shift       = accept & ~search_done_reg & ~over_limit;
    assign ctrl.clear       = accept & item.last_byte;
    assign ctrl.ignore_case = ignore_case_reg;

    // Row of window cells, newest byte in cell 0
    assign hits[0] = 1'b1;
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        logic [LenW-1:0]  pat_idx;
        logic [ByteW-1:0] shift_src;
        logic             in_use;

        // Cell k lines up with pattern byte (length - 1 - k)
        assign in_use    = (LenW'(k) < eff_len);
        assign pat_idx   = eff_len - LenW'(1) - LenW'(k);
        assign targets[k] = pattern_bytes_reg[pat_idx[2:0]*ByteW +: ByteW];

        if (k == 0)
        begin : g_head
            assign shift_src = item.data_byte;
        end
        else
        begin : g_body
            assign shift_src = window[k-1];
        end

        bss_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .shift_in (shift_src),
            .target   (targets[k]),
            .in_use   (in_use),
            .hit_in   (hits[k]),
            .byte_out (window[k]),
            .hit_out  (hits[k+1])
        );
    end

    assign count_plus1 = byte_count_reg + PosW'(1);
    assign match = hits[MAX_PATTERN] &&
                   (count_plus1 >= PosW'(eff_len)) &&
                   !((eff_len == LenW'(1)) && item.last_byte);

    // Decide the outcome of this byte
    always_comb
    begin
        emit                   = 1'b0;
        outcome.found          = 1'b0;
        outcome.match_position = '0;
        if (!search_done_reg)
        begin
            if (over_limit)
            begin
                emit = 1'b1;
            end
            else if (eff_len == '0)
            begin
                emit          = 1'b1;
                outcome.found = (item.data_byte != '0);
            end
            else if (item.data_byte == '0)
            begin
                emit = 1'b1;
            end
            else if (match)
            begin
                emit                   = 1'b1;
                outcome.found          = 1'b1;
                outcome.match_position = count_plus1 - PosW'(eff_len);
            end
            else if (item.last_byte)
            begin
                emit = 1'b1;
            end
        end
    end

    // Per-buffer counters
    always_comb
    begin
        byte_count_next  = byte_count_reg;
        search_done_next = search_done_reg;
        if (accept)
        begin
            if (item.last_byte)
            begin
                byte_count_next  = '0;
                search_done_next = 1'b0;
            end
            else
            begin
                if (ctrl.shift)
                begin
                    byte_count_next = count_plus1;
                end
                if (emit)
                begin
                    search_done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            search_done_reg <= 1'b0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            search_done_reg <= search_done_next;
        end
    end

    // Result register
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (accept && emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            result_reg <= outcome;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    // The last byte of a buffer always leaves clean per-buffer state
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last_byte) |=> (byte_count_reg == '0 && !search_done_reg))
        else $error("per-buffer state not cleared after last byte");

    // A not-found result carries offset zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.found) |-> (result.match_position == '0))
        else $error("not-found result with nonzero offset");

    // Input is held back only while a result waits under stall
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled without a waiting result");

    // Byte count never passes the buffer limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= PosW'(MAX_BUFFER))
        else $error("byte count beyond buffer limit");
`endif

endmodule

// File: tb/bounded_substring_search_tb.sv
// Self-checking testbench for bounded_substring_search: directed buffers and random buffers
// across several register settings, checked against a predictor.
// Depends on bss_pkg and the bounded_substring_search RTL.
module bounded_substring_search_tb;
    import bss_pkg::*;

    localparam int          MaxPattern   = DefMaxPattern;
    localparam int unsigned MaxBuffer    = DefMaxBuffer;
    localparam int unsigned CycleLimit   = 1000000;
    localparam int unsigned SettleCycles = 4;
    localparam int unsigned HoldCycles   = 400;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    item_t                item         = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index    = '0;
    logic [PatW-1:0]      cfg_data     = '0;

    // Stimulus and checking state
    item_t       bytes_to_send [$];
    result_t     search_outcomes [$];
    result_t     want;
    int unsigned send_gap    = 0;
    int unsigned stall_left  = 0;
    int unsigned hold_left   = 0;
    bit          hold_used   = 1'b0;
    bit          hold_armed  = 1'b0;
    bit          steady_flow = 1'b0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Register mirror and per-buffer search state
    logic [PatW-1:0]  pat_cfg  = '0;
    logic [LenW-1:0]  len_cfg  = '0;
    logic             fold_cfg = 1'b0;
    logic [ByteW-1:0] window [MaxPattern];
    int unsigned      taken_count = 0;
    bit               answered    = 1'b0;

    bounded_substring_search i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Fold upper case to lower when the mirror says so
    function automatic logic [ByteW-1:0] lowered(input logic [ByteW-1:0] c);
        return (fold_cfg && c >= CharUpperA && c <= CharUpperZ) ? c + CaseOffset : c;
    endfunction

    // Advance the search by one byte and queue the outcome it decides, if any
    function automatic void advance_search(input item_t it);
        int unsigned idx;
        int unsigned lim;
        int unsigned m;
        bit          emit;
        bit          hit;
        result_t     r;
        idx  = taken_count;
        emit = 1'b0;
        r    = '0;
        if (!answered)
        begin
            if (idx >= MaxBuffer)
            begin
                emit = 1'b1;
            end
            else
            begin
                // pattern ends at its length or at its first zero byte
                lim = (len_cfg > MaxPattern) ? MaxPattern : len_cfg;
                m = 0;
                while (m < lim && pat_cfg[m*ByteW +: ByteW] != '0)
                    m++;
                for (int k = MaxPattern - 1; k > 0; k--)
                    window[k] = window[k-1];
                window[0]   = it.data_byte;
                taken_count = idx + 1;
                if (m == 0)
                begin
                    emit    = 1'b1;
                    r.found = (it.data_byte != '0);
                end
                else if (it.data_byte == '0)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    // a one-byte pattern may not match on the final byte
                    hit = (idx + 1 >= m) && !(m == 1 && it.last_byte);
                    for (int j = 0; j < m; j++)
                        if (lowered(window[m-1-j]) != lowered(pat_cfg[j*ByteW +: ByteW]))
                            hit = 1'b0;
                    if (hit)
                    begin
                        emit             = 1'b1;
                        r.found          = 1'b1;
                        r.match_position = PosW'(idx + 1 - m);
                    end
                    else if (it.last_byte)
                    begin
                        emit = 1'b1;
                    end
                end
            end
            if (emit)
            begin
                search_outcomes.push_back(r);
                answered = 1'b1;
            end
        end
        if (it.last_byte)
        begin
            foreach (window[k])
                window[k] = '0;
            taken_count = 0;
            answered    = 1'b0;
        end
    endfunction

    // Idle length for either side: mostly none, some short, a few long
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_flow)
            return 0;
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic void push_byte(input logic [ByteW-1:0] d, input logic last);
        item_t t;
        t.data_byte = d;
        t.last_byte = last;
        bytes_to_send.push_back(t);
    endfunction

    // Letters of a string as one buffer, last flag on the final letter
    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], i == s.len() - 1);
    endfunction

    function automatic void log_failure(input string msg);
        if (error_count < 10)
            $display("%s", msg);
        error_count++;
    endfunction

    task automatic write_register(input logic [CfgIndexW-1:0] index,
                                  input logic [PatW-1:0]      data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            REG_PATTERN_BYTES:  pat_cfg  = data;
            REG_PATTERN_LENGTH: len_cfg  = data[LenW-1:0];
            REG_IGNORE_CASE:    fold_cfg = data[0];
            default: ;
        endcase
    endtask

    // Unused upper bits of the narrow registers carry random junk
    task automatic configure(input logic [PatW-1:0] pat, input logic [LenW-1:0] len,
                             input logic fold);
        logic [PatW-1:0] junk;
        junk = {$urandom, $urandom};
        write_register(REG_PATTERN_BYTES, pat);
        write_register(REG_PATTERN_LENGTH, {junk[PatW-1:LenW], len});
        write_register(REG_IGNORE_CASE, {junk[PatW-1:1], fold});
    endtask

    // Wait until every byte is taken and every outcome has come back
    task automatic wait_idle();
        do @(negedge clk);
        while (bytes_to_send.size() != 0 || item_valid || search_outcomes.size() != 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Random pattern, then buffers that often carry it, sometimes damaged
    task automatic random_phase(input logic [LenW-1:0] len, input logic fold,
                                input int unsigned budget);
        string            letters;
        logic [PatW-1:0]  pat;
        logic [ByteW-1:0] c;
        int unsigned      queued;
        int unsigned      blen;
        int unsigned      plen;
        int unsigned      r;
        int               start;
        bit               plant;
        letters = "abcdABCDx@[`{";
        for (int s = 0; s < PatSlots; s++)
        begin
            if ($urandom_range(0, 99) < 8)
                c = '0;
            else
                c = letters[$urandom_range(0, letters.len() - 1)];
            pat[s*ByteW +: ByteW] = c;
        end
        plen = (len > MaxPattern) ? MaxPattern : len;
        configure(pat, len, fold);
        @(negedge clk);
        queued = 0;
        while (queued < budget)
        begin
            blen  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
            plant = ($urandom_range(0, 2) != 0) && (plen != 0);
            start = $urandom_range(0, blen - 1);
            for (int i = 0; i < blen; i++)
            begin
                if (plant && i >= start && i - start < plen)
                begin
                    c = pat[(i-start)*ByteW +: ByteW];
                    if ((c | CaseOffset) >= "a" && (c | CaseOffset) <= "z"
                        && $urandom_range(0, 9) < (fold ? 5 : 1))
                        c = c ^ CaseOffset;
                    if ($urandom_range(0, 19) == 0)
                        c = c ^ 8'h01;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 4)
                        c = '0;
                    else if (r < 16)
                        c = ByteW'($urandom_range(0, 255));
                    else
                        c = letters[$urandom_range(0, letters.len() - 1)];
                end
                push_byte(c, i == blen - 1);
            end
            queued += blen;
        end
    endtask

    // Driver: offers queued bytes, holds them while stalled, predicts on each transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_gap   <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                advance_search(item);
            if (!(item_valid && item_stall))
            begin
                if (send_gap != 0)
                begin
                    send_gap   <= send_gap - 1;
                    item_valid <= 1'b0;
                end
                else if (bytes_to_send.size() != 0)
                begin
                    item       <= bytes_to_send.pop_front();
                    item_valid <= 1'b1;
                    send_gap   <= idle_length();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off on the result side, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_armed && !hold_used)
        begin
            hold_left <= HoldCycles;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result-side stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else if (hold_left != 0)
        begin
            result_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            stall_left   <= idle_length();
            result_stall <= 1'b0;
        end
    end

    // Monitor: compare each result transaction with the oldest predicted outcome
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (search_outcomes.size() == 0)
            begin
                log_failure($sformatf("unexpected result found=%0d pos=%0d",
                                      result.found, result.match_position));
            end
            else
            begin
                want = search_outcomes.pop_front();
                if (result.found !== want.found
                    || result.match_position !== want.match_position)
                    log_failure($sformatf(
                        "mismatch: expected found=%0d pos=%0d, got found=%0d pos=%0d",
                        want.found, want.match_position,
                        result.found, result.match_position));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("FAIL bounded_substring_search");
            $finish;
        end
    end

    initial
    begin
        logic [LenW-1:0] opening_lengths [4];
        opening_lengths = '{4'd8, 4'd1, 4'd15, 4'd0};
        foreach (window[k])
            window[k] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty pattern, nonzero and zero first byte
        @(negedge clk);
        push_byte(8'h41, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);

        // Two-letter pattern with case folding; zero byte before a match
        wait_idle();
        configure(64'h6261, 4'd2, 1'b1);
        @(negedge clk);
        queue_text("xAB");
        push_byte("a", 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte("b", 1'b1);

        // One-byte pattern: a match on the final byte alone is rejected
        wait_idle();
        configure(64'h71, 4'd1, 1'b0);
        @(negedge clk);
        queue_text("q");
        queue_text("Qq");
        queue_text("qz");

        // Length above the maximum counts as eight; full-width match
        wait_idle();
        configure(64'hFFEE_DDCC_BBAA_9988, 4'd15, 1'b0);
        @(negedge clk);
        for (int i = 0; i < MaxPattern; i++)
            push_byte(ByteW'(8'h88 + 8'h11 * i), i == MaxPattern - 1);

        // Zero byte inside the pattern shortens it
        wait_idle();
        configure(64'h0063_6261, 4'd8, 1'b1);
        @(negedge clk);
        queue_text("zABC");

        // Random settings and buffers
        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            @(negedge clk);
            steady_flow = (p == 2);
            random_phase((p < 4) ? opening_lengths[p] : LenW'($urandom_range(0, 15)),
                         p[0], 45);
            if (p == 5)
                hold_armed = 1'b1;
        end

        wait_idle();
        if (error_count == 0 && search_outcomes.size() == 0)
            $display("PASS bounded_substring_search");
        else
            $display("FAIL bounded_substring_search");
        $finish;
    end

endmodule

// File: bounded_substring_search.f
design/bss_pkg.sv
design/bss_cell.sv
design/bounded_substring_search.sv
tb/bounded_substring_search_tb.sv
